[rtl/encoder_and_button_qualifier_defines.svh]
// Assertion macros for the verification of the encoder and button qualifier
`ifndef ENCODER_AND_BUTTON_QUALIFIER_DEFINES_SVH
`define ENCODER_AND_BUTTON_QUALIFIER_DEFINES_SVH

// Implication in the same cycle, disabled while reset is asserted.
`define EBQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ebq check failed");

// Implication into the following cycle, disabled while reset is asserted.
`define EBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ebq check failed");

`endif

[rtl/ebq_pkg.sv]
// Package with the result type, event codes and register indexes of the qualifier
`default_nettype none

package ebq_pkg;

    typedef logic [2:0] event_kind_t;
    typedef logic [2:0] cfg_index_t;

    localparam event_kind_t EV_STEP       = 3'd0;
    localparam event_kind_t EV_PRESS      = 3'd1;
    localparam event_kind_t EV_RELEASE    = 3'd2;
    localparam event_kind_t EV_CLICK      = 3'd3;
    localparam event_kind_t EV_LONG_PRESS = 3'd4;
    localparam event_kind_t EV_REPEAT     = 3'd5;
    localparam event_kind_t EV_SECOND     = 3'd6;

    localparam cfg_index_t REG_BUTTON_INTERVAL = 3'd0;
    localparam cfg_index_t REG_SECOND_INTERVAL = 3'd1;
    localparam cfg_index_t REG_CLICK_GAP       = 3'd2;
    localparam cfg_index_t REG_LONG_PRESS      = 3'd3;
    localparam cfg_index_t REG_REPEAT_PERIOD   = 3'd4;

    localparam int CFG_DATA_W = 16;
    localparam int MAX_RESULTS = 4;
    localparam int NUM_CAND = 7;

    localparam logic [7:0] DEBOUNCE_RESET = 8'h02;
    localparam logic [7:0] DEBOUNCE_PRESS = 8'h7f;
    localparam logic [7:0] DEBOUNCE_RELEASE = 8'h80;

    localparam logic [3:0] HIST_CCW = 4'h2;
    localparam logic [3:0] HIST_CW  = 4'h8;

    localparam logic signed [1:0] DIR_NONE = 2'sd0;
    localparam logic signed [1:0] DIR_UP   = 2'sd1;
    localparam logic signed [1:0] DIR_DOWN = -2'sd1;

    typedef struct packed {
        event_kind_t       kind;
        logic signed [1:0] dir;
        logic [7:0]        clicks;
    } result_t;

endpackage

`default_nettype wire

[rtl/encoder_and_button_qualifier.sv]
// Quadrature encoder decoder and push-button qualifier, one transaction per timer tick.
// Each input transaction is one timer tick. It is captured in an input register, then
// decoded in a single combinational pass into up to four results (step, press, release,
// click, long press, repeat, one second, in that order), which load a four-entry result
// buffer. The result channel drains that buffer one result per cycle while out_ready is
// high, and the final result of a tick carries last_event. A new tick is accepted every
// cycle while the buffer keeps pace: the next tick is decoded in the cycle its
// predecessor's final result is taken. The first result is presented once the tick
// has passed the input register and been loaded into the result buffer at decode; a
// tick with no results leaves the block when it is decoded. Configuration registers
// are written through cfg_write/cfg_index/cfg_data and take effect on the next tick.
`default_nettype none

module encoder_and_button_qualifier #(
    parameter int COUNTER_WIDTH = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [1:0]                encoder_pins,
    input  wire logic                      button_level,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output ebq_pkg::event_kind_t           event_kind,
    output logic signed [1:0]              step_direction,
    output logic [7:0]                     clicks,
    output logic                           last_event,
    input  wire logic                      cfg_write,
    input  wire ebq_pkg::cfg_index_t       cfg_index,
    input  wire logic [15:0]               cfg_data
);
    import ebq_pkg::*;

    localparam int CMP_W = (COUNTER_WIDTH > CFG_DATA_W) ? COUNTER_WIDTH : CFG_DATA_W;
    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

    // True when v is a multiple of 2**e; an exponent at or above the width needs v zero.
    function automatic logic is_mult(input logic [COUNTER_WIDTH-1:0] v, input logic [3:0] e);
        logic [COUNTER_WIDTH-1:0] m;
        for (int i = 0; i < COUNTER_WIDTH; i++)
        begin
            m[i] = (i < int'(e));
        end
        return (v & m) == '0;
    endfunction

    // configuration
    logic [3:0]  btn_log2_reg;
    logic [3:0]  sec_log2_reg;
    logic [15:0] gap_limit_reg;
    logic [15:0] long_count_reg;
    logic [3:0]  rep_log2_reg;

    // tick state
    logic [COUNTER_WIDTH-1:0] tick_reg, tick_next;
    logic [3:0]               hist_reg, hist_next;
    logic [7:0]               db_reg, db_next;
    logic                     pressed_reg, pressed_next;
    logic                     released_reg, released_next;
    logic [COUNTER_WIDTH-1:0] hold_reg, hold_next;
    logic [COUNTER_WIDTH-1:0] gap_reg, gap_next;
    logic [7:0]               tally_reg, tally_next;

    // input register
    logic       in_vld_reg;
    logic [1:0] pins_reg;
    logic       level_reg;
    logic       dec_fire;

    // result buffer
    result_t    ent_reg [MAX_RESULTS];
    result_t    ent_next [MAX_RESULTS];
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] idx_reg;
    logic       buf_last;
    logic       buf_free;

    // decode
    logic                     btn_gate;
    logic                     is_press;
    logic                     is_release;
    logic [COUNTER_WIDTH-1:0] hold_inc;
    logic [COUNTER_WIDTH-1:0] gap_inc;
    logic [7:0]               tally_cancel;
    logic                     cand_vld [NUM_CAND];
    result_t                  cand [NUM_CAND];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            btn_log2_reg   <= 4'd4;
            sec_log2_reg   <= 4'd11;
            gap_limit_reg  <= 16'd100;
            long_count_reg <= 16'd256;
            rep_log2_reg   <= 4'd7;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BUTTON_INTERVAL: btn_log2_reg   <= cfg_data[3:0];
                REG_SECOND_INTERVAL: sec_log2_reg   <= cfg_data[3:0];
                REG_CLICK_GAP:       gap_limit_reg  <= cfg_data;
                REG_LONG_PRESS:      long_count_reg <= cfg_data;
                REG_REPEAT_PERIOD:   rep_log2_reg   <= cfg_data[3:0];
                default:             ;
            endcase
        end
    end

    assign buf_last = ({1'b0, idx_reg} + 3'd1) == cnt_reg;
    assign buf_free = (cnt_reg == '0) || (out_ready && buf_last);
    assign dec_fire = in_vld_reg && buf_free;
    assign in_ready = !in_vld_reg || dec_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pins_reg  <= encoder_pins;
            level_reg <= button_level;
        end
    end

    always_comb
    begin
        tick_next = tick_reg + 1'b1;
        hist_next = {hist_reg[1:0], pins_reg};
        btn_gate  = is_mult(tick_next, btn_log2_reg);

        hold_inc = (pressed_reg && hold_reg != CNT_MAX) ? hold_reg + 1'b1 : hold_reg;
        gap_inc  = (released_reg && gap_reg != CNT_MAX) ? gap_reg + 1'b1 : gap_reg;
        db_next  = {db_reg[6:0], ~level_reg};
        is_press   = btn_gate && (db_next == DEBOUNCE_PRESS);
        is_release = btn_gate && (db_next == DEBOUNCE_RELEASE);

        tally_cancel = tally_reg;
        if (is_press && CMP_W'(gap_inc) > CMP_W'(gap_limit_reg))
        begin
            tally_cancel = 8'd1;
        end
        if (is_release && CMP_W'(hold_inc) > CMP_W'(gap_limit_reg))
        begin
            tally_cancel = 8'd0;
        end

        pressed_next  = pressed_reg;
        released_next = released_reg;
        hold_next     = hold_reg;
        gap_next      = gap_reg;
        tally_next    = tally_reg;
        if (btn_gate)
        begin
            hold_next  = hold_inc;
            gap_next   = gap_inc;
            tally_next = tally_cancel;
            if (is_press)
            begin
                pressed_next  = 1'b1;
                released_next = 1'b0;
                hold_next     = '0;
            end
            if (is_release)
            begin
                pressed_next  = 1'b0;
                released_next = 1'b1;
                gap_next      = '0;
                tally_next    = tally_cancel + 8'd1;
            end
        end

        for (int k = 0; k < NUM_CAND; k++)
        begin
            cand[k] = '{kind: EV_STEP, dir: DIR_NONE, clicks: 8'd0};
        end
        cand[0].dir    = (hist_next == HIST_CCW) ? DIR_DOWN : DIR_UP;
        cand_vld[0]    = (hist_next == HIST_CCW) || (hist_next == HIST_CW);
        cand[1].kind   = EV_PRESS;
        cand_vld[1]    = is_press;
        cand[2].kind   = EV_RELEASE;
        cand_vld[2]    = is_release;
        cand[3].kind   = EV_CLICK;
        cand[3].clicks = tally_cancel;
        cand_vld[3]    = is_release && (tally_cancel != 8'd0);
        cand[4].kind   = EV_LONG_PRESS;
        cand_vld[4]    = btn_gate && pressed_next
                         && (CMP_W'(hold_next) == CMP_W'(long_count_reg));
        cand[5].kind   = EV_REPEAT;
        cand_vld[5]    = btn_gate && pressed_next
                         && (CMP_W'(hold_next) > CMP_W'(long_count_reg))
                         && is_mult(hold_next, rep_log2_reg);
        cand[6].kind   = EV_SECOND;
        cand_vld[6]    = is_mult(tick_next, sec_log2_reg);

        // pack the present events in order into the buffer slots
        cnt_next = '0;
        for (int j = 0; j < MAX_RESULTS; j++)
        begin
            ent_next[j] = cand[0];
        end
        for (int k = 0; k < NUM_CAND; k++)
        begin
            if (cand_vld[k] && cnt_next < 3'(MAX_RESULTS))
            begin
                ent_next[cnt_next[1:0]] = cand[k];
                cnt_next = cnt_next + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            hist_reg     <= '0;
            db_reg       <= DEBOUNCE_RESET;
            pressed_reg  <= 1'b0;
            released_reg <= 1'b0;
            hold_reg     <= '0;
            gap_reg      <= '0;
            tally_reg    <= '0;
        end
        else if (dec_fire)
        begin
            tick_reg     <= tick_next;
            hist_reg     <= hist_next;
            pressed_reg  <= pressed_next;
            released_reg <= released_next;
            hold_reg     <= hold_next;
            gap_reg      <= gap_next;
            tally_reg    <= tally_next;
            if (btn_gate)
            begin
                db_reg <= db_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (dec_fire)
        begin
            cnt_reg <= cnt_next;
            idx_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            if (buf_last)
            begin
                cnt_reg <= '0;
                idx_reg <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_fire)
        begin
            for (int j = 0; j < MAX_RESULTS; j++)
            begin
                ent_reg[j] <= ent_next[j];
            end
        end
    end

    assign out_valid      = cnt_reg != '0;
    assign event_kind     = ent_reg[idx_reg].kind;
    assign step_direction = ent_reg[idx_reg].dir;
    assign clicks         = ent_reg[idx_reg].clicks;
    assign last_event     = buf_last;

endmodule

`default_nettype wire

[rtl/ebq_checker.sv]
// Port-level checker for the encoder and button qualifier, with its bind
`default_nettype none
`include "encoder_and_button_qualifier_defines.svh"

module ebq_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire ebq_pkg::event_kind_t event_kind,
    input wire logic signed [1:0]   step_direction,
    input wire logic [7:0]          clicks,
    input wire logic                last_event
);
    import ebq_pkg::*;

    // only step results carry a direction, and then a nonzero one
    `EBQ_ASSERT_SAME(a_dir_only_on_step, clk, rst_n,
        out_valid && event_kind != EV_STEP, step_direction == DIR_NONE)
    `EBQ_ASSERT_SAME(a_step_has_dir, clk, rst_n,
        out_valid && event_kind == EV_STEP,
        step_direction == DIR_UP || step_direction == DIR_DOWN)
    // click counts appear only on click results, and are never zero there
    `EBQ_ASSERT_SAME(a_clicks_only_on_click, clk, rst_n,
        out_valid && event_kind != EV_CLICK, clicks == 8'd0)
    `EBQ_ASSERT_SAME(a_click_nonzero, clk, rst_n,
        out_valid && event_kind == EV_CLICK, clicks != 8'd0)
    // a stalled result holds
    `EBQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(event_kind) && $stable(clicks) && $stable(last_event))

endmodule

bind encoder_and_button_qualifier ebq_checker u_ebq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_kind     (event_kind),
    .step_direction (step_direction),
    .clicks         (clicks),
    .last_event     (last_event)
);

`default_nettype wire
